// File: hw/rtl/ppom_pkg.sv
// Package for the pixel point operation mapper: mode codes, register
// layout, thresholds and reciprocal constants. Depends on nothing.
package ppom_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned MODE_W = 4;

    // Mode codes held in the map_mode register.
    localparam logic [MODE_W-1:0] MODE_IDENTITY  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_GAMMA     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_NEGATIVE  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_STRETCH   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_COMPRESS  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_POSTERIZE = 4'd5;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BOUNDED   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CONTOUR   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SOLARIZE  = 4'd9;

    // Register index of map_mode on the configuration port.
    localparam logic REG_MAP_MODE = 1'b0;

    // Gray level constants.
    localparam logic [PIX_W-1:0] PIX_MAX        = 8'd255;
    localparam logic [PIX_W-1:0] STRETCH_LO     = 8'd30;
    localparam logic [PIX_W-1:0] STRETCH_HI     = 8'd225;
    localparam logic [PIX_W-1:0] COMPRESS_OFS   = 8'd30;
    localparam logic [PIX_W-1:0] POSTER_MASK    = 8'hE0;
    localparam logic [PIX_W-1:0] THRESH_LEVEL   = 8'd128;
    localparam logic [PIX_W-1:0] BOUND_LO       = 8'd80;
    localparam logic [PIX_W-1:0] BOUND_MID      = 8'd120;
    localparam logic [PIX_W-1:0] BOUND_HI       = 8'd160;
    localparam logic [4:0]       CONTOUR_HALF   = 5'd16;
    localparam logic [PIX_W-1:0] SOLAR_LEVEL    = 8'd180;

    // Rational gains and reciprocals (scaled by 2^16) for exact division.
    localparam logic [4:0]  STRETCH_NUM = 5'd17;
    localparam logic [3:0]  COMPRESS_NUM = 4'd13;
    localparam logic [12:0] RECIP_13    = 13'd5042;
    localparam logic [11:0] RECIP_17    = 12'd3856;

endpackage

// File: hw/rtl/pixel_point_operation_mapper_unit.sv
// Top level of the pixel point operation mapper: a four-stage pipeline
// that maps one gray pixel per clock while m_axis_tready stays high. Depends on ppom_pkg.
//
// Pixels enter on the s_axis word channel, one 8-bit gray level per word
// with tlast marking the final pixel of an image, and leave on m_axis in
// the same order, one mapped word per input word, with tlast copied.
// The map_mode register at byte address 0 of the APB port selects one of
// ten point operations; codes above nine pass pixels unchanged. Change it
// only while no pixels are in flight.
// Throughput is one word per clock while m_axis_tready stays high. A word
// passes four register stages before it appears on m_axis: an input
// register, a stage of small constant products (the square and the
// stretch and compression gains), a stage that divides by 255 with shifts
// and adds and by 13 and 17 with reciprocal multiplies, and the output
// register where the mode selects the result. Each stage holds while the
// one after it is full and stalled, so a low m_axis_tready backs up
// through the stages and drops s_axis_tready only once all four are
// full; nothing is lost or repeated.
// Reset clears all stage valid bits and sets map_mode to identity.
module pixel_point_operation_mapper_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Input pixel stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tlast,   // last_in
    // Output pixel stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic        m_axis_tlast,   // last_out
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned PW = ppom_pkg::PIX_W;
    localparam int unsigned MW = ppom_pkg::MODE_W;

    // Configuration register.
    logic [MW-1:0] map_mode_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ppom_pkg::REG_MAP_MODE);
    assign prdata    = (paddr[2] == ppom_pkg::REG_MAP_MODE) ? {28'd0, map_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg <= ppom_pkg::MODE_IDENTITY;
        end
        else if (cfg_write)
        begin
            map_mode_reg <= pwdata[MW-1:0];
        end
    end

    // Stage valid bits and advance chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !v4_reg || m_axis_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: input register.
    logic [PW-1:0] pix1_reg;
    logic          last1_reg;
    logic [MW-1:0] mode1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            pix1_reg  <= s_axis_tdata;
            last1_reg <= s_axis_tlast;
            mode1_reg <= map_mode_reg;
        end
    end

    // Stage 2: constant products. The stretch product is only meaningful
    // for levels of 30 and up; the select stage ignores it elsewhere.
    logic [15:0]   sq2_reg,  sq2_next;
    logic [11:0]   st2_reg,  st2_next;
    logic [11:0]   cp2_reg,  cp2_next;
    logic [PW-1:0] pix2_reg;
    logic          last2_reg;
    logic [MW-1:0] mode2_reg;
    logic [PW-1:0] st_diff;

    assign st_diff = pix1_reg - ppom_pkg::STRETCH_LO;

    always_comb
    begin
        sq2_next = 16'(pix1_reg) * 16'(pix1_reg);
        st2_next = 12'(st_diff) * 12'(ppom_pkg::STRETCH_NUM);
        cp2_next = 12'(pix1_reg) * 12'(ppom_pkg::COMPRESS_NUM);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            sq2_reg   <= sq2_next;
            st2_reg   <= st2_next;
            cp2_reg   <= cp2_next;
            pix2_reg  <= pix1_reg;
            last2_reg <= last1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    // Stage 3: exact divisions by 255, 13 and 17. For x below 2^16,
    // x/255 equals (x + 1 + x/256)/256; the other two use 16-bit
    // reciprocals scaled by 2^16 whose rounding error stays below one for these ranges.
    logic [PW-1:0] gam3_reg, gam3_next;
    logic [PW-1:0] str3_reg, str3_next;
    logic [PW-1:0] cmp3_reg, cmp3_next;
    logic [PW-1:0] pix3_reg;
    logic          last3_reg;
    logic [MW-1:0] mode3_reg;
    logic [16:0]   gam_sum;
    logic [24:0]   str_prod;
    logic [23:0]   cmp_prod;

    always_comb
    begin
        gam_sum   = 17'(sq2_reg) + 17'd1 + 17'(sq2_reg[15:8]);
        str_prod  = 25'(st2_reg) * 25'(ppom_pkg::RECIP_13);
        cmp_prod  = 24'(cp2_reg) * 24'(ppom_pkg::RECIP_17);
        gam3_next = gam_sum[15:8];
        str3_next = str_prod[23:16];
        cmp3_next = cmp_prod[23:16] + ppom_pkg::COMPRESS_OFS;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            gam3_reg  <= gam3_next;
            str3_reg  <= str3_next;
            cmp3_reg  <= cmp3_next;
            pix3_reg  <= pix2_reg;
            last3_reg <= last2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    // Stage 4: mode select into the output register.
    logic [PW-1:0] pix4_reg, pix4_next;
    logic          last4_reg;

    always_comb
    begin
        case (mode3_reg)
            ppom_pkg::MODE_GAMMA:
            begin
                pix4_next = gam3_reg;
            end
            ppom_pkg::MODE_NEGATIVE:
            begin
                pix4_next = ppom_pkg::PIX_MAX - pix3_reg;
            end
            ppom_pkg::MODE_STRETCH:
            begin
                if (pix3_reg < ppom_pkg::STRETCH_LO)
                begin
                    pix4_next = '0;
                end
                else if (pix3_reg > ppom_pkg::STRETCH_HI)
                begin
                    pix4_next = ppom_pkg::PIX_MAX;
                end
                else
                begin
                    pix4_next = str3_reg;
                end
            end
            ppom_pkg::MODE_COMPRESS:
            begin
                pix4_next = cmp3_reg;
            end
            ppom_pkg::MODE_POSTERIZE:
            begin
                pix4_next = pix3_reg & ppom_pkg::POSTER_MASK;
            end
            ppom_pkg::MODE_THRESHOLD:
            begin
                pix4_next = (pix3_reg < ppom_pkg::THRESH_LEVEL) ? '0 : ppom_pkg::PIX_MAX;
            end
            ppom_pkg::MODE_BOUNDED:
            begin
                if (pix3_reg > ppom_pkg::BOUND_LO && pix3_reg < ppom_pkg::BOUND_MID)
                begin
                    pix4_next = ppom_pkg::BOUND_LO;
                end
                else if (pix3_reg >= ppom_pkg::BOUND_MID && pix3_reg < ppom_pkg::BOUND_HI)
                begin
                    pix4_next = ppom_pkg::BOUND_HI;
                end
                else
                begin
                    pix4_next = pix3_reg;
                end
            end
            ppom_pkg::MODE_CONTOUR:
            begin
                pix4_next = (pix3_reg[4:0] < ppom_pkg::CONTOUR_HALF) ? '0 : pix3_reg;
            end
            ppom_pkg::MODE_SOLARIZE:
            begin
                pix4_next = (pix3_reg < ppom_pkg::SOLAR_LEVEL) ? pix3_reg
                                                               : ppom_pkg::PIX_MAX - pix3_reg;
            end
            default:
            begin
                // Identity, and the unused codes above nine.
                pix4_next = pix3_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            pix4_reg  <= pix4_next;
            last4_reg <= last3_reg;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = pix4_reg;
    assign m_axis_tlast  = last4_reg;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for pixel_point_operation_mapper_unit: streams gray
// pixels through every map mode and checks each mapped word against a predictor.
// Depends on ppom_pkg and the mapper RTL.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One pixel word as it travels on either stream: gray level plus last flag.
    typedef struct packed {
        logic [ppom_pkg::PIX_W-1:0] level;
        logic                       last;
    } pixel_word_t;

    // Byte addresses on the configuration port. Index 1 holds no register,
    // so writes there must leave map_mode untouched.
    localparam logic [2:0] ADDR_MAP_MODE = 3'(4 * int'(ppom_pkg::REG_MAP_MODE));
    localparam logic [2:0] ADDR_SPARE    = 3'(4 * (int'(ppom_pkg::REG_MAP_MODE) + 1));

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned SETTLE      = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] pixel_in
    logic        s_axis_tlast = 1'b0;  // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] pixel_out
    logic        m_axis_tlast;         // last_out

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Words waiting to be offered, and mapped words waiting to come out.
    pixel_word_t pixel_feed_q[$];
    pixel_word_t mapped_q[$];

    // Shadow copy of the map_mode register.
    logic [ppom_pkg::MODE_W-1:0] mode_shadow = ppom_pkg::MODE_IDENTITY;

    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Random idle rates, redrawn every so often so that calm stretches occur.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned send_gap = 0;
    int unsigned recv_hold = 0;
    logic        quiet = 1'b0;
    logic        long_hold_req = 1'b0;
    logic        long_hold_done = 1'b0;

    pixel_word_t next_word;
    pixel_word_t head_word;

    // Gray levels that sit on a decision edge of some mode.
    logic [7:0]  edge_levels[] = '{8'd0, 8'd15, 8'd16, 8'd29, 8'd30, 8'd31, 8'd32, 8'd79,
                                   8'd80, 8'd81, 8'd119, 8'd120, 8'd121, 8'd127, 8'd128,
                                   8'd159, 8'd160, 8'd161, 8'd179, 8'd180, 8'd181,
                                   8'd224, 8'd225, 8'd226, 8'd254, 8'd255};

    pixel_point_operation_mapper_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 clk = ~clk;

    // Predicted gray level for one pixel under a given mode. Undefined mode
    // codes fall through to identity.
    function automatic logic [7:0] map_level(input logic [ppom_pkg::MODE_W-1:0] mode,
                                             input logic [7:0] v);
        int unsigned x;
        x = v;
        case (mode)
            ppom_pkg::MODE_GAMMA:     return 8'((x * x) / 255);
            ppom_pkg::MODE_NEGATIVE:  return 8'(255 - x);
            ppom_pkg::MODE_STRETCH:
            begin
                if (x < 30)
                    return 8'd0;
                if (x > 225)
                    return 8'd255;
                return 8'((17 * (x - 30)) / 13);
            end
            ppom_pkg::MODE_COMPRESS:  return 8'((13 * x) / 17 + 30);
            ppom_pkg::MODE_POSTERIZE: return 8'(x - (x % 32));
            ppom_pkg::MODE_THRESHOLD: return (x < 128) ? 8'd0 : 8'd255;
            ppom_pkg::MODE_BOUNDED:
            begin
                if (x > 80 && x < 120)
                    return 8'd80;
                if (x >= 120 && x < 160)
                    return 8'd160;
                return v;
            end
            ppom_pkg::MODE_CONTOUR:   return ((x % 32) < 16) ? 8'd0 : v;
            ppom_pkg::MODE_SOLARIZE:  return (x < 180) ? v : 8'(255 - x);
            default:                  return v;
        endcase
    endfunction

    // Sender. A word is taken from the feed queue whenever the bus is free;
    // short random gaps are inserted unless the run is in its quiet tail.
    // The expectation is recorded at the edge where the word is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                mapped_q.push_back('{level: map_level(mode_shadow, s_axis_tdata),
                                     last: s_axis_tlast});
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_feed_q.size() != 0 && !quiet &&
                         $urandom_range(0, 99) < send_idle_pct)
                begin
                    // Idle burst of random length, this one included.
                    send_gap      <= $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_feed_q.size() != 0)
                begin
                    next_word      = pixel_feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.level;
                    s_axis_tlast  <= next_word.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver and checker. Every word taken off the output is compared
    // with the oldest expectation. Ready drops in short random bursts, and
    // once for a long stretch so that the pipeline backs up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready  <= 1'b0;
            recv_hold      <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (mapped_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected word: expected none, actual level %0d last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    head_word = mapped_q.pop_front();
                    if (m_axis_tdata !== head_word.level)
                    begin
                        err_cnt++;
                        $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                                 $time, head_word.level, m_axis_tdata);
                    end
                    if (m_axis_tlast !== head_word.last)
                    begin
                        err_cnt++;
                        $display("%0t: last_out mismatch: expected %0b, actual %0b",
                                 $time, head_word.last, m_axis_tlast);
                    end
                end
            end

            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                recv_hold      <= LONG_HOLD;
                m_axis_tready  <= 1'b0;
            end
            else if (recv_hold != 0)
            begin
                recv_hold     <= recv_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < recv_stall_pct)
            begin
                recv_hold     <= $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Cycle counter: redraws idle rates and ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 128 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       send_idle_pct <= 0;
                1:       send_idle_pct <= 15;
                default: send_idle_pct <= 40;
            endcase
            case ($urandom_range(0, 2))
                0:       recv_stall_pct <= 0;
                1:       recv_stall_pct <= 15;
                default: recv_stall_pct <= 40;
            endcase
        end
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Two-phase APB write; the register takes the data at the access edge.
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads map_mode back and compares it with the shadow copy.
    task automatic cfg_check_mode();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAP_MODE;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(mode_shadow))
        begin
            err_cnt++;
            $display("%0t: map_mode readback mismatch: expected %0d, actual %0d",
                     $time, mode_shadow, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Only the low nibble of a map_mode write is kept.
    task automatic set_mode(input logic [31:0] data);
        cfg_write(ADDR_MAP_MODE, data);
        mode_shadow = data[ppom_pkg::MODE_W-1:0];
        cfg_check_mode();
    endtask

    // Waits until every queued word went in and every mapped word came out,
    // then lets the pipeline settle before the register is touched again.
    task automatic drain();
        do
            @(posedge clk);
        while (pixel_feed_q.size() != 0 || s_axis_tvalid || mapped_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_pixel(input logic [7:0] level, input logic last);
        pixel_feed_q.push_back('{level: level, last: last});
    endtask

    // Random words: a quarter of them land on a decision edge of some mode.
    task automatic queue_random(input int unsigned count);
        logic [7:0] level;
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                level = edge_levels[$urandom_range(0, edge_levels.size() - 1)];
            else
                level = 8'($urandom_range(0, 255));
            queue_pixel(level, $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin
        logic [31:0] cfg_value;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register must come out of reset as identity.
        cfg_check_mode();

        // Directed part: edge pixels for each mode, with both last values among them.
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b1);
        drain();
        set_mode(32'(ppom_pkg::MODE_GAMMA));
        queue_pixel(8'd255, 1'b0);
        queue_pixel(8'd16, 1'b0);
        drain();
        set_mode(32'(ppom_pkg::MODE_NEGATIVE));
        queue_pixel(8'd0, 1'b1);
        queue_pixel(8'd255, 1'b0);
        drain();
        // Upper bits of the write data must be dropped, leaving stretch.
        set_mode(32'hFFFF_FFF0 | 32'(ppom_pkg::MODE_STRETCH));
        queue_pixel(8'd29, 1'b0);
        queue_pixel(8'd226, 1'b0);
        queue_pixel(8'd30, 1'b1);
        drain();
        set_mode(32'(ppom_pkg::MODE_COMPRESS));
        queue_pixel(8'd0, 1'b0);
        queue_pixel(8'd255, 1'b0);
        drain();
        // A write to an unused address must not disturb the mode.
        cfg_write(ADDR_SPARE, 32'(ppom_pkg::MODE_POSTERIZE));
        cfg_check_mode();
        set_mode(32'(ppom_pkg::MODE_POSTERIZE));
        queue_pixel(8'd31, 1'b0);
        queue_pixel(8'd224, 1'b1);
        drain();
        set_mode(32'(ppom_pkg::MODE_THRESHOLD));
        queue_pixel(8'd127, 1'b0);
        queue_pixel(8'd128, 1'b0);
        drain();
        set_mode(32'(ppom_pkg::MODE_BOUNDED));
        queue_pixel(8'd80, 1'b0);
        queue_pixel(8'd81, 1'b0);
        queue_pixel(8'd120, 1'b1);
        queue_pixel(8'd160, 1'b0);
        drain();
        set_mode(32'(ppom_pkg::MODE_CONTOUR));
        queue_pixel(8'd15, 1'b0);
        queue_pixel(8'd16, 1'b0);
        drain();
        set_mode(32'(ppom_pkg::MODE_SOLARIZE));
        queue_pixel(8'd179, 1'b0);
        queue_pixel(8'd180, 1'b1);
        drain();
        // Highest code: undefined, so the pixel passes unchanged.
        set_mode(32'hF);
        queue_pixel(8'd170, 1'b0);
        queue_pixel(8'd85, 1'b0);
        drain();

        // Random part. The first ten phases walk through every defined mode;
        // later ones pick any code, undefined ones and junk upper bits too.
        for (int unsigned p = 0; p < 14; p++)
        begin
            if (p < 10)
                cfg_value = p;
            else if ($urandom_range(0, 2) == 0)
                cfg_value = $urandom();
            else
                cfg_value = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                cfg_write(ADDR_SPARE, $urandom());
            set_mode(cfg_value);

            if (p == 5)
            begin
                // Long receiver hold while the sender keeps offering words,
                // so the pipeline fills and input ready must drop.
                long_hold_req = 1'b1;
                queue_random(85);
            end
            else if (p == 8)
            begin
                // Sender stops halfway until every mapped word has come out.
                queue_random(40);
                drain();
                queue_random(45);
            end
            else
                queue_random(85);
            drain();
        end

        // Quiet tail: no idling on either side, back-to-back words.
        quiet = 1'b1;
        set_mode($urandom_range(0, 9));
        queue_random(60);
        drain();
        repeat (SETTLE) @(posedge clk);

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
